>>> rtl/prle_pkg.sv
// Shared types and constants for the pixel run-length decoder.
package prle_pkg;

  localparam int PixelBytesW = 3;
  localparam int TotalW      = 20;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 20;
  localparam int PixelW      = 32;
  localparam int CountW      = 7;
  localparam int RunW        = 8;

  localparam logic [CfgIdxW-1:0] RegPixelBytes  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegTotalPixels = 1'd1;

  localparam logic [PixelBytesW-1:0] PixelBytesReset = 3'd2;
  localparam logic [TotalW-1:0]      TotalReset      = 20'd0;

  localparam logic [1:0] PhCtrl    = 2'd0;
  localparam logic [1:0] PhRepeat  = 2'd1;
  localparam logic [1:0] PhLiteral = 2'd2;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        byte_index;
    logic [PixelW-1:0] pixel_accum;
    logic [RunW-1:0]   run_left;
    logic [TotalW-1:0] pixels_written;
  } prle_state_t;

  typedef struct packed {
    logic              valid;
    logic [PixelW-1:0] pixel_value;
    logic [CountW-1:0] repeat_count;
    logic              image_done;
    logic              from_literal;
  } prle_result_t;

endpackage

>>> rtl/prle_ifs.sv
// Valid/ready channel interfaces for compressed bytes and decoded pixel runs.
interface prle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] comp_byte;
  logic       start_image;

  modport source (output valid, output comp_byte, output start_image, input ready);
  modport sink   (input valid, input comp_byte, input start_image, output ready);
endinterface

interface prle_pix_if;
  logic                                valid;
  logic                                ready;
  logic [prle_pkg::PixelW-1:0]         pixel_value;
  logic [prle_pkg::CountW-1:0]         repeat_count;
  logic                                image_done;

  modport source (output valid, output pixel_value, output repeat_count, output image_done,
                  input ready);
  modport sink   (input valid, input pixel_value, input repeat_count, input image_done,
                  output ready);
endinterface

>>> rtl/prle_step.sv
// Next-state and result logic for one compressed byte.
module prle_step (
  input  logic [prle_pkg::PixelBytesW-1:0] pixel_bytes,
  input  logic [prle_pkg::TotalW-1:0]      total_pixels,
  input  prle_pkg::prle_state_t            st,
  input  logic [7:0]                       comp_byte,
  input  logic                             start_image,
  output prle_pkg::prle_state_t            st_next,
  output prle_pkg::prle_result_t           res
);

  prle_pkg::prle_state_t            cur;
  logic [2:0]                       eff_bytes;
  logic [prle_pkg::PixelW-1:0]      accum;
  logic [prle_pkg::TotalW-1:0]      remaining;
  logic [prle_pkg::TotalW-1:0]      written_sum;
  logic [prle_pkg::RunW-1:0]        n;
  logic [prle_pkg::RunW-1:0]        run_dec;
  logic                             literal;

  always_comb begin
    if (pixel_bytes == 3'd0) begin
      eff_bytes = 3'd1;
    end else if (pixel_bytes > 3'd4) begin
      eff_bytes = 3'd4;
    end else begin
      eff_bytes = pixel_bytes;
    end
  end

  always_comb begin
    cur = st;
    if (start_image) begin
      cur = '0;
      cur.phase = prle_pkg::PhCtrl;
    end
    st_next     = cur;
    res         = '0;
    accum       = cur.pixel_accum
                  | ({24'd0, comp_byte} << {cur.byte_index, 3'b000});
    remaining   = total_pixels - cur.pixels_written;
    run_dec     = cur.run_left - 8'd1;
    literal     = (cur.phase == prle_pkg::PhLiteral);
    n           = '0;
    written_sum = cur.pixels_written;

    if (cur.pixels_written >= total_pixels) begin
      st_next = cur;
    end else if (cur.phase != prle_pkg::PhRepeat && cur.phase != prle_pkg::PhLiteral) begin
      if (!comp_byte[7]) begin
        st_next.run_left = comp_byte;
        st_next.phase    = prle_pkg::PhRepeat;
      end else begin
        st_next.run_left = 8'd0 - comp_byte;
        st_next.phase    = prle_pkg::PhLiteral;
      end
      st_next.byte_index  = 2'd0;
      st_next.pixel_accum = '0;
    end else if (({1'b0, cur.byte_index} + 3'd1) < eff_bytes) begin
      st_next.pixel_accum = accum;
      st_next.byte_index  = cur.byte_index + 2'd1;
    end else begin
      if (!literal) begin
        n = ({12'd0, cur.run_left} > remaining) ? remaining[7:0] : cur.run_left;
        st_next.phase    = prle_pkg::PhCtrl;
        st_next.run_left = '0;
      end else begin
        n = 8'd1;
        st_next.run_left = run_dec;
        if (run_dec == 8'd0) begin
          st_next.phase = prle_pkg::PhCtrl;
        end
      end
      st_next.byte_index  = 2'd0;
      st_next.pixel_accum = '0;
      written_sum = cur.pixels_written + {12'd0, n};
      if (n != 8'd0) begin
        st_next.pixels_written = written_sum;
        res.valid        = 1'b1;
        res.pixel_value  = accum;
        res.repeat_count = n[6:0];
        res.image_done   = (written_sum == total_pixels);
        res.from_literal = literal;
      end
    end
  end

endmodule

>>> rtl/pixel_rle_run_decoder_unit.sv
// Top level of the pixel run-length decoder: registers, config and output stage.
// Latency: a result is valid on the cycle after its last pixel byte is accepted.
// Throughput: one compressed byte per clock; the decoder state loop is a single
// register stage; input stalls only while a result is held and pix_out.ready is low.
// Reset: pixel_bytes returns to 2, total_pixels to 0, decoder state clears, and the
// output channel goes empty.
module pixel_rle_run_decoder_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [prle_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [prle_pkg::CfgDataW-1:0]  cfg_data,
  prle_byte_if.sink                      byte_in,
  prle_pix_if.source                     pix_out
);

  logic [prle_pkg::PixelBytesW-1:0] pixel_bytes;
  logic [prle_pkg::TotalW-1:0]      total_pixels;
  prle_pkg::prle_state_t            st;
  prle_pkg::prle_state_t            st_next;
  prle_pkg::prle_result_t           res;
  logic                             accept;
  logic                             out_valid;
  logic [prle_pkg::PixelW-1:0]      out_value;
  logic [prle_pkg::CountW-1:0]      out_count;
  logic                             out_done;

  assign byte_in.ready = !out_valid || pix_out.ready;
  assign accept        = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes  <= prle_pkg::PixelBytesReset;
      total_pixels <= prle_pkg::TotalReset;
    end else if (cfg_we) begin
      case (cfg_index)
        prle_pkg::RegPixelBytes:  pixel_bytes  <= cfg_data[prle_pkg::PixelBytesW-1:0];
        prle_pkg::RegTotalPixels: total_pixels <= cfg_data[prle_pkg::TotalW-1:0];
        default: ;
      endcase
    end
  end

  prle_step u_step (
    .pixel_bytes  (pixel_bytes),
    .total_pixels (total_pixels),
    .st           (st),
    .comp_byte    (byte_in.comp_byte),
    .start_image  (byte_in.start_image),
    .st_next      (st_next),
    .res          (res)
  );

  // all-zero state is phase PhCtrl with everything cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= res.valid;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      out_value <= res.pixel_value;
      out_count <= res.repeat_count;
      out_done  <= res.image_done;
    end
  end

  assign pix_out.valid        = out_valid;
  assign pix_out.pixel_value  = out_value;
  assign pix_out.repeat_count = out_count;
  assign pix_out.image_done   = out_done;

  a_literal_count_one: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.from_literal |-> res.repeat_count == 7'd1)
    else $error("literal pixel with repeat count other than one");

  a_no_zero_run: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid |-> pix_out.repeat_count != 7'd0)
    else $error("result with zero repeat count");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !byte_in.ready |-> out_valid)
    else $error("input stalled with empty output register");

  a_start_bounds_count: assert property (@(posedge clk) disable iff (rst)
    accept && byte_in.start_image |=> st.pixels_written <= 20'd127)
    else $error("pixel count not cleared by new image");

endmodule

>>> dv/prle_run_checker.sv
`timescale 1ns / 1ps
// Checker for the pixel run-length decoder: tracks config, predicts pixel runs, compares them.
module prle_run_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [prle_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [prle_pkg::CfgDataW-1:0] cfg_data,
  prle_byte_if                          byte_ch,
  prle_pix_if                           pix_ch,
  output int                            runs_pending,
  output int                            runs_checked,
  output int                            fail_count
);

  typedef struct packed {
    logic [prle_pkg::PixelW-1:0] pixel;
    logic [prle_pkg::CountW-1:0] count;
    logic                        done;
  } pixel_run_t;

  pixel_run_t runs_due[$];

  logic [prle_pkg::PixelBytesW-1:0] pixel_bytes_q;
  logic [prle_pkg::TotalW-1:0]      total_q;
  logic [1:0]                       phase_q;
  logic [1:0]                       byte_idx_q;
  logic [prle_pkg::PixelW-1:0]      accum_q;
  logic [prle_pkg::RunW-1:0]        run_left_q;
  logic [prle_pkg::TotalW-1:0]      written_q;

  function automatic void clear_decode();
    phase_q    = prle_pkg::PhCtrl;
    byte_idx_q = '0;
    accum_q    = '0;
    run_left_q = '0;
    written_q  = '0;
  endfunction

  function automatic int unsigned bytes_per_pixel();
    if (pixel_bytes_q == '0) return 1;
    if (pixel_bytes_q > 3'd4) return 4;
    return 32'(pixel_bytes_q);
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    int unsigned n;
    int unsigned left;
    pixel_run_t  run;
    if (restart) clear_decode();
    if (written_q >= total_q) return;
    if (phase_q != prle_pkg::PhRepeat && phase_q != prle_pkg::PhLiteral) begin
      if (b <= 8'h7F) begin
        run_left_q = b;
        phase_q    = prle_pkg::PhRepeat;
      end else begin
        run_left_q = -b;
        phase_q    = prle_pkg::PhLiteral;
      end
      byte_idx_q = '0;
      accum_q    = '0;
      return;
    end
    accum_q = accum_q | (prle_pkg::PixelW'(b) << (8 * byte_idx_q));
    if (int'(byte_idx_q) + 1 < bytes_per_pixel()) begin
      byte_idx_q = byte_idx_q + 2'd1;
      return;
    end
    left = total_q - written_q;
    if (phase_q == prle_pkg::PhRepeat) begin
      n = run_left_q;
      if (n > left) n = left;
      phase_q    = prle_pkg::PhCtrl;
      run_left_q = '0;
    end else begin
      n = 1;
      run_left_q = run_left_q - 8'd1;
      if (run_left_q == '0) phase_q = prle_pkg::PhCtrl;
    end
    run.pixel  = accum_q;
    byte_idx_q = '0;
    accum_q    = '0;
    if (n == 0) return;
    written_q = written_q + prle_pkg::TotalW'(n);
    run.count = prle_pkg::CountW'(n);
    run.done  = (written_q == total_q);
    runs_due.push_back(run);
  endfunction

  function automatic void check_run();
    pixel_run_t want;
    if (runs_due.size() == 0) begin
      $error("unexpected pixel run: pixel_value %h repeat_count %0d image_done %0b",
             pix_ch.pixel_value, pix_ch.repeat_count, pix_ch.image_done);
      fail_count++;
      return;
    end
    want = runs_due.pop_front();
    if (pix_ch.pixel_value !== want.pixel) begin
      $error("pixel_value: expected %h, got %h", want.pixel, pix_ch.pixel_value);
      fail_count++;
    end
    if (pix_ch.repeat_count !== want.count) begin
      $error("repeat_count: expected %0d, got %0d", want.count, pix_ch.repeat_count);
      fail_count++;
    end
    if (pix_ch.image_done !== want.done) begin
      $error("image_done: expected %0b, got %0b", want.done, pix_ch.image_done);
      fail_count++;
    end
    runs_checked++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pixel_bytes_q = prle_pkg::PixelBytesReset;
      total_q       = prle_pkg::TotalReset;
      clear_decode();
      runs_due.delete();
    end else begin
      if (pix_ch.valid && pix_ch.ready) check_run();
      if (cfg_we) begin
        if (cfg_index == prle_pkg::RegPixelBytes) begin
          pixel_bytes_q = cfg_data[prle_pkg::PixelBytesW-1:0];
        end else if (cfg_index == prle_pkg::RegTotalPixels) begin
          total_q = cfg_data[prle_pkg::TotalW-1:0];
        end
      end
      if (byte_ch.valid && byte_ch.ready) decode_byte(byte_ch.comp_byte, byte_ch.start_image);
    end
    runs_pending <= runs_due.size();
  end

endmodule

>>> dv/pixel_rle_run_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the pixel run-length decoder: stimulus, config writes and verdict.
module pixel_rle_run_decoder_unit_tb;

  localparam int CycleLimit = 200000;
  localparam int ByteTarget = 640;
  localparam int ImageBudget = 70;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [prle_pkg::CfgIdxW-1:0]  cfg_index;
  logic [prle_pkg::CfgDataW-1:0] cfg_data;

  int runs_pending;
  int runs_checked;
  int fail_count;
  int bytes_sent = 0;
  int images = 0;
  int reg_writes = 0;
  int burst_left = 0;
  int cycle_count = 0;
  logic [7:0] ready_tick = '0;

  prle_byte_if byte_ch ();
  prle_pix_if  pix_ch ();

  pixel_rle_run_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .byte_in   (byte_ch),
    .pix_out   (pix_ch)
  );

  prle_run_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_ch      (byte_ch),
    .pix_ch       (pix_ch),
    .runs_pending (runs_pending),
    .runs_checked (runs_checked),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("pixel_rle_run_decoder_unit_tb failed");
      $finish;
    end
  end

  // receiver stall pattern: always ready, coin flip, 1-in-8, mostly ready
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (rst) begin
      pix_ch.ready <= 1'b0;
    end else begin
      case (ready_tick[7:6])
        2'd0: pix_ch.ready <= 1'b1;
        2'd1: pix_ch.ready <= 1'($urandom_range(0, 1));
        2'd2: pix_ch.ready <= (ready_tick[2:0] == 3'd0);
        default: pix_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        byte_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
    end
    burst_left--;
    byte_ch.valid       <= 1'b1;
    byte_ch.comp_byte   <= b;
    byte_ch.start_image <= restart;
    do @(posedge clk); while (!byte_ch.ready);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [prle_pkg::CfgIdxW-1:0] idx,
                           input logic [prle_pkg::CfgDataW-1:0] value);
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (runs_pending != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [7:0] pixel_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // one image: mostly well-formed repeat/literal runs, some stray bytes and restarts
  task automatic random_image();
    logic [prle_pkg::PixelBytesW-1:0] size_sel;
    logic [prle_pkg::TotalW-1:0]      pixel_total;
    int unsigned                      eff;
    int unsigned                      tally;
    int unsigned                      start_count;
    int unsigned                      len;
    int unsigned                      cnt;
    logic                             first;
    logic                             restart;
    size_sel = ($urandom_range(0, 4) == 0) ? prle_pkg::PixelBytesW'($urandom_range(0, 7))
                                           : prle_pkg::PixelBytesW'($urandom_range(1, 4));
    case ($urandom_range(0, 11))
      0: pixel_total = '1;
      1: pixel_total = prle_pkg::TotalW'($urandom);
      2, 3: pixel_total = prle_pkg::TotalW'($urandom_range(1, 3));
      default: pixel_total = prle_pkg::TotalW'($urandom_range(4, 300));
    endcase
    if ($urandom_range(0, 1) == 0) begin
      write_reg(prle_pkg::RegPixelBytes, prle_pkg::CfgDataW'(size_sel));
      write_reg(prle_pkg::RegTotalPixels, prle_pkg::CfgDataW'(pixel_total));
    end else begin
      write_reg(prle_pkg::RegTotalPixels, prle_pkg::CfgDataW'(pixel_total));
      write_reg(prle_pkg::RegPixelBytes, prle_pkg::CfgDataW'(size_sel));
    end
    eff = (size_sel == '0) ? 1 : (size_sel > 3'd4) ? 4 : 32'(size_sel);
    tally = 0;
    first = 1'b1;
    start_count = bytes_sent;
    while (tally < pixel_total && bytes_sent - start_count < ImageBudget) begin
      case ($urandom_range(0, 9))
        0: begin
          restart = 1'($urandom_range(0, 1)) | first;
          send_byte(8'($urandom), restart);
          if (restart) tally = 0;
        end
        1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 9))
            0: cnt = 0;
            1: cnt = 127;
            2: cnt = $urandom_range(0, 127);
            default: cnt = $urandom_range(1, 10);
          endcase
          send_byte(8'(cnt), first);
          repeat (eff) send_byte(pixel_byte(), 1'b0);
          tally += cnt;
        end
        default: begin
          len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 128) : $urandom_range(1, 8);
          send_byte(8'(256 - len), first);
          for (int i = 0; i < len && tally < pixel_total &&
               bytes_sent - start_count < ImageBudget; i++) begin
            repeat (eff) send_byte(pixel_byte(), 1'b0);
            tally++;
          end
        end
      endcase
      first = 1'b0;
    end
    images++;
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= '0;
    cfg_data            <= '0;
    byte_ch.valid       <= 1'b0;
    byte_ch.comp_byte   <= '0;
    byte_ch.start_image <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // total of zero after reset: byte is dropped
    send_byte(8'h55, 1'b0);
    write_reg(prle_pkg::RegTotalPixels, prle_pkg::CfgDataW'(10));
    // zero-length repeat, then a 127 repeat clipped to the total
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    write_reg(prle_pkg::RegPixelBytes, prle_pkg::CfgDataW'(4));
    write_reg(prle_pkg::RegTotalPixels, '1);
    // single literal, then a 128 literal; size drops mid-pixel
    send_byte(8'hFF, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h80, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    write_reg(prle_pkg::RegPixelBytes, prle_pkg::CfgDataW'(1));
    send_byte(8'h56, 1'b0);
    // total lowered below pixels already written
    write_reg(prle_pkg::RegTotalPixels, prle_pkg::CfgDataW'(1));
    send_byte(8'hAA, 1'b0);
    // pixel size zero acts as one byte
    write_reg(prle_pkg::RegPixelBytes, prle_pkg::CfgDataW'(0));
    write_reg(prle_pkg::RegTotalPixels, prle_pkg::CfgDataW'(3));
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    images += 4;

    while (bytes_sent < ByteTarget) random_image();
    byte_ch.valid <= 1'b0;

    do @(posedge clk); while (runs_pending != 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("covered %0d compressed bytes over %0d images and %0d register writes",
             bytes_sent, images, reg_writes);
    $display("%0d pixel runs checked, %0d mismatches", runs_checked, fail_count);
    if (fail_count == 0) $display("pixel_rle_run_decoder_unit_tb passed");
    else $display("pixel_rle_run_decoder_unit_tb failed");
    $finish;
  end

endmodule

>>> files.f
rtl/prle_pkg.sv
rtl/prle_ifs.sv
rtl/prle_step.sv
rtl/pixel_rle_run_decoder_unit.sv
dv/prle_run_checker.sv
dv/pixel_rle_run_decoder_unit_tb.sv
